### hw/rtl/sprite_page_blitter_assert.svh
// ----------------------------------------------------------------------------
// sprite_page_blitter_assert.svh - assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SPRITE_PAGE_BLITTER_ASSERT_SVH
`define SPRITE_PAGE_BLITTER_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define SPB_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("spb assertion failed");

// Condition must never hold out of reset.
`define SPB_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("spb forbidden condition");

`else

`define SPB_ASSERT(label, clk, rst_n, prop)
`define SPB_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

### hw/rtl/spb_pkg.sv
// ----------------------------------------------------------------------------
// spb_pkg - sprite page blitter package
// Sizes, bus command codes, sequencer state and controller/datapath structs.
// ----------------------------------------------------------------------------
package spb_pkg;

    localparam int SPRITE_COLS   = 16;
    localparam int COLS_PER_CHIP = 64;
    localparam int STORE_DEPTH   = 2 * SPRITE_COLS;

    localparam int COL_W   = $clog2(SPRITE_COLS);
    localparam int CNT_W   = $clog2(SPRITE_COLS + 1);
    localparam int IDX_W   = 5;
    localparam int X_W     = 7;
    localparam int XS_W    = X_W + 1;
    localparam int Y_W     = 6;
    localparam int CCOL_W  = 6;
    localparam int PAGE_W  = 3;
    localparam int PCNT_W  = 2;

    localparam logic       OP_LOAD      = 1'b0;
    localparam logic       OP_DRAW      = 1'b1;
    localparam logic [7:0] CMD_COL_SET  = 8'h40;
    localparam logic [7:0] CMD_PAGE_SET = 8'hB8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COL,
        ST_PAGE,
        ST_DATA
    } state_t;

    typedef struct packed {
        logic   load;
        logic   start;
        logic   inc_col;
        logic   next_page;
        logic   next_part;
        state_t phase;
    } ctrl_cmd_t;

    typedef struct packed {
        logic zero_count;
        logic col_last;
        logic page_last;
        logic part_last;
    } dp_status_t;

endpackage

### hw/rtl/sprite_page_blitter.sv
// ----------------------------------------------------------------------------
// sprite_page_blitter - 16x16 sprite blitter for a two-controller page LCD
// Stores a sprite as column bytes and streams column/page commands and data.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_ready): op=0 loads one sprite byte at
//   byte_index (slots 0-15 upper page, 16-31 lower page); op=1 draws the
//   sprite at pos_x/pos_y, mirrored when facing_left is set.
//   Write channel (wr_valid/wr_ready): one bus write per beat - chip_sel,
//   is_data, bus_byte - with last set on the final beat of a draw.
// Latency and throughput:
//   A load produces no beat and leaves the sequencer idle. A draw issues
//   its first beat the cycle after acceptance and then one beat per cycle
//   while wr_ready is high: 36 beats for an aligned row, 54 for an unaligned
//   row, 40 (aligned) or 60 (unaligned) for a split across the controllers.
//   The next item is taken the cycle after the last beat. Sprite bytes come
//   from two 16-entry RAMs with registered reads, addressed from the next
//   counter values so the data lines up with the beat.
// Reset: the sequencer returns to idle; the sprite store is undefined
//   until loaded.
// Stall: when wr_ready is low the beat holds, counters freeze and the RAMs
//   keep re-reading the same column.
// ----------------------------------------------------------------------------
module sprite_page_blitter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  logic                      op,
    input  logic [spb_pkg::IDX_W-1:0] byte_index,
    input  logic [7:0]                byte_value,
    input  logic [spb_pkg::X_W-1:0]   pos_x,
    input  logic [spb_pkg::Y_W-1:0]   pos_y,
    input  logic                      facing_left,
    output logic                      wr_valid,
    input  logic                      wr_ready,
    output logic                      chip_sel,
    output logic                      is_data,
    output logic [7:0]                bus_byte,
    output logic                      last
);

    import spb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: owns both handshakes and the last flag
    spb_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .op         (op),
        .wr_valid   (wr_valid),
        .wr_ready   (wr_ready),
        .last       (last),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath: sprite store, geometry, counters and byte formation
    spb_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .byte_index  (byte_index),
        .byte_value  (byte_value),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .facing_left (facing_left),
        .chip_sel    (chip_sel),
        .is_data     (is_data),
        .bus_byte    (bus_byte)
    );

endmodule

### hw/rtl/spb_ram.sv
// ----------------------------------------------------------------------------
// spb_ram - generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module spb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/spb_ctrl.sv
// ----------------------------------------------------------------------------
// spb_ctrl - blitter sequencer
// Walks column command, page command and data beats for every page and part.
// ----------------------------------------------------------------------------
`include "sprite_page_blitter_assert.svh"

module spb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                op,
    output logic                wr_valid,
    input  logic                wr_ready,
    output logic                last,
    input  spb_pkg::dp_status_t status,
    output spb_pkg::ctrl_cmd_t  cmd
);

    import spb_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   item_fire;
    logic   wr_fire;

    assign item_ready = (state_reg == ST_IDLE);
    assign wr_valid   = (state_reg != ST_IDLE);
    assign item_fire  = item_valid && item_ready;
    assign wr_fire    = wr_valid && wr_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        logic end_page;
        end_page   = 1'b0;
        state_next = state_reg;
        cmd        = '0;
        cmd.phase  = state_reg;
        last       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    if (op == OP_DRAW)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_COL;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_COL:
            begin
                if (wr_fire)
                begin
                    state_next = ST_PAGE;
                end
            end
            ST_PAGE:
            begin
                if (status.zero_count)
                begin
                    end_page = 1'b1;
                end
                else if (wr_fire)
                begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (status.col_last)
                begin
                    end_page = 1'b1;
                end
                else if (wr_fire)
                begin
                    cmd.inc_col = 1'b1;
                end
            end
        endcase

        // close the page: next page, next part, or done
        last = end_page && status.page_last && status.part_last;
        if (end_page && wr_fire)
        begin
            if (!status.page_last)
            begin
                cmd.next_page = 1'b1;
                state_next    = ST_COL;
            end
            else if (!status.part_last)
            begin
                cmd.next_part = 1'b1;
                state_next    = ST_COL;
            end
            else
            begin
                state_next = ST_IDLE;
            end
        end
    end

    `SPB_ASSERT_NEVER(a_ready_while_busy, clk, rst_n, item_ready && wr_valid)
    `SPB_ASSERT(a_last_not_col, clk, rst_n, last |-> (wr_valid && state_reg != ST_COL))
    `SPB_ASSERT(a_last_to_idle, clk, rst_n, (wr_fire && last) |=> item_ready)
    `SPB_ASSERT(a_draw_starts, clk, rst_n,
        (item_fire && op == OP_DRAW) |=> (state_reg == ST_COL))

endmodule

### hw/rtl/spb_datapath.sv
// ----------------------------------------------------------------------------
// spb_datapath - sprite store, counters and bus byte formation
// Holds draw geometry, page/part/column counters and the two sprite RAMs.
// ----------------------------------------------------------------------------
module spb_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  spb_pkg::ctrl_cmd_t           cmd,
    output spb_pkg::dp_status_t          status,
    input  logic [spb_pkg::IDX_W-1:0]    byte_index,
    input  logic [7:0]                   byte_value,
    input  logic [spb_pkg::X_W-1:0]      pos_x,
    input  logic [spb_pkg::Y_W-1:0]      pos_y,
    input  logic                         facing_left,
    output logic                         chip_sel,
    output logic                         is_data,
    output logic [7:0]                   bus_byte
);

    import spb_pkg::*;

    // draw geometry, latched at start
    logic              split_reg;
    logic              chip0_reg;
    logic [CCOL_W-1:0] col0_reg;
    logic [CNT_W-1:0]  left_reg;
    logic              mirror_reg;
    logic [PAGE_W-1:0] page0_reg;
    logic [2:0]        off_reg;

    // sequencing counters
    logic              part_reg,  part_next;
    logic [PCNT_W-1:0] page_reg,  page_next;
    logic [COL_W-1:0]  col_reg,   col_next;

    logic              split_in;
    logic              chip0_in;
    logic [X_W-1:0]    colx_in;
    logic [X_W-1:0]    left_x;
    logic [CNT_W-1:0]  left_next;
    logic              mirror_next;
    logic [CNT_W-1:0]  count_cur;
    logic [CNT_W-1:0]  first_next;
    logic [CNT_W-1:0]  colsum;
    logic [COL_W-1:0]  rd_idx;
    logic [COL_W-1:0]  rd_addr;
    logic [PCNT_W-1:0] page_max;

    logic              up_we, lo_we;
    logic [COL_W-1:0]  lo_waddr;
    logic [7:0]        up_rdata, lo_rdata;
    logic [23:0]       shifted;
    logic [7:0]        pixel;
    logic [PAGE_W-1:0] page_num;

    // geometry of the incoming draw
    assign split_in = (({1'b0, pos_x} + XS_W'(SPRITE_COLS)) >= XS_W'(COLS_PER_CHIP))
                   && ({1'b0, pos_x} < XS_W'(COLS_PER_CHIP));
    assign chip0_in = ({1'b0, pos_x} >= XS_W'(COLS_PER_CHIP));
    assign colx_in  = chip0_in ? (pos_x - X_W'(COLS_PER_CHIP)) : pos_x;
    assign left_x   = X_W'(COLS_PER_CHIP) - pos_x;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            split_reg  <= split_in;
            chip0_reg  <= chip0_in;
            col0_reg   <= colx_in[CCOL_W-1:0];
            left_reg   <= left_x[CNT_W-1:0];
            mirror_reg <= facing_left;
            page0_reg  <= pos_y[Y_W-1:3];
            off_reg    <= pos_y[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg <= 1'b0;
            page_reg <= '0;
            col_reg  <= '0;
        end
        else
        begin
            part_reg <= part_next;
            page_reg <= page_next;
            col_reg  <= col_next;
        end
    end

    always_comb
    begin
        part_next = part_reg;
        page_next = page_reg;
        col_next  = col_reg;
        priority if (cmd.start)
        begin
            part_next = 1'b0;
            page_next = '0;
            col_next  = '0;
        end
        else if (cmd.next_part)
        begin
            part_next = 1'b1;
            page_next = '0;
            col_next  = '0;
        end
        else if (cmd.next_page)
        begin
            page_next = page_reg + PCNT_W'(1);
            col_next  = '0;
        end
        else if (cmd.inc_col)
        begin
            col_next = col_reg + COL_W'(1);
        end
    end

    // status for the sequencer
    assign count_cur = part_reg ? (CNT_W'(SPRITE_COLS) - left_reg)
                                : (split_reg ? left_reg : CNT_W'(SPRITE_COLS));
    assign page_max  = (off_reg == 3'd0) ? PCNT_W'(1) : PCNT_W'(2);

    assign status.zero_count = (count_cur == '0);
    assign status.col_last   = (({1'b0, col_reg} + CNT_W'(1)) == count_cur);
    assign status.page_last  = (page_reg == page_max);
    assign status.part_last  = !split_reg || part_reg;

    // read address follows the next counters so data lines up with the beat
    assign left_next   = cmd.start ? left_x[CNT_W-1:0] : left_reg;
    assign mirror_next = cmd.start ? facing_left : mirror_reg;
    assign first_next  = part_next ? left_next : '0;
    assign colsum      = first_next + {1'b0, col_next};
    assign rd_idx      = colsum[COL_W-1:0];
    assign rd_addr     = mirror_next ? (COL_W'(SPRITE_COLS - 1) - rd_idx) : rd_idx;

    // store writes: upper page bytes first, then lower page bytes
    assign up_we    = cmd.load && ({1'b0, byte_index} < (IDX_W + 1)'(SPRITE_COLS));
    assign lo_we    = cmd.load && ({1'b0, byte_index} >= (IDX_W + 1)'(SPRITE_COLS))
                   && ({1'b0, byte_index} < (IDX_W + 1)'(STORE_DEPTH));
    assign lo_waddr = COL_W'(byte_index - IDX_W'(SPRITE_COLS));

    spb_ram #(
        .WIDTH (8),
        .DEPTH (SPRITE_COLS)
    ) u_upper_ram (
        .clk   (clk),
        .we    (up_we),
        .waddr (byte_index[COL_W-1:0]),
        .wdata (byte_value),
        .raddr (rd_addr),
        .rdata (up_rdata)
    );

    spb_ram #(
        .WIDTH (8),
        .DEPTH (SPRITE_COLS)
    ) u_lower_ram (
        .clk   (clk),
        .we    (lo_we),
        .waddr (lo_waddr),
        .wdata (byte_value),
        .raddr (rd_addr),
        .rdata (lo_rdata)
    );

    // shift the column pair by the row offset; each page takes one byte of it
    assign shifted = {8'h00, lo_rdata, up_rdata} << off_reg;

    always_comb
    begin
        unique case (page_reg)
            2'd0:    pixel = shifted[7:0];
            2'd1:    pixel = shifted[15:8];
            2'd2:    pixel = shifted[23:16];
            default: pixel = 8'h00;
        endcase
    end

    assign page_num = page0_reg + PAGE_W'(page_reg);
    assign chip_sel = part_reg || chip0_reg;
    assign is_data  = (cmd.phase == ST_DATA);

    always_comb
    begin
        unique case (cmd.phase)
            ST_COL:  bus_byte = CMD_COL_SET | {2'b00, col0_reg & {CCOL_W{!part_reg}}};
            ST_PAGE: bus_byte = CMD_PAGE_SET | {5'b00000, page_num};
            ST_DATA: bus_byte = pixel;
            ST_IDLE: bus_byte = 8'h00;
        endcase
    end

endmodule

### dv/tb_sprite_page_blitter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sprite_page_blitter - sprite blitter bus write stream check
// Loads the sprite store, then drives directed and random draws while both
// channels idle and stall at random. Every write beat is compared field by
// field against a local prediction of the LCD command and data stream.
// ----------------------------------------------------------------------------
module tb_sprite_page_blitter;

    import spb_pkg::*;

    // One bus write as it leaves the block.
    typedef struct packed {
        logic       chip;
        logic       is_data;
        logic [7:0] data;
        logic       last;
    } bus_write_t;

    // Receiver stall patterns; each holds for a random stretch of cycles.
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_HICCUP,
        RX_CHOKE
    } rx_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    logic                 op = OP_LOAD;
    logic [IDX_W-1:0]     byte_index = '0;
    logic [7:0]           byte_value = '0;
    logic [X_W-1:0]       pos_x = '0;
    logic [Y_W-1:0]       pos_y = '0;
    logic                 facing_left = 1'b0;
    logic                 wr_valid;
    logic                 wr_ready = 1'b0;
    logic                 chip_sel;
    logic                 is_data;
    logic [7:0]           bus_byte;
    logic                 last;

    // Local copy of the sprite store and the queue of predicted bus writes.
    logic [7:0]           sprite_mem [STORE_DEPTH];
    bus_write_t           pending_writes [$];

    int                   error_count = 0;
    int                   beats_checked = 0;
    int                   loads_sent = 0;
    int                   draws_sent = 0;
    int                   split_draws = 0;
    int                   mirrored_draws = 0;
    int                   wrapped_draws = 0;

    rx_mode_t             rx_mode = RX_STREAM;
    int                   rx_hold = 0;

    sprite_page_blitter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .op          (op),
        .byte_index  (byte_index),
        .byte_value  (byte_value),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .facing_left (facing_left),
        .wr_valid    (wr_valid),
        .wr_ready    (wr_ready),
        .chip_sel    (chip_sel),
        .is_data     (is_data),
        .bus_byte    (bus_byte),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Pixel byte of one sprite column on page slot pg of the draw. With a
    // row offset the two stored bytes straddle three pages, so shift each
    // and OR the neighbor in on the middle page.
    function automatic logic [7:0] pixel_column(input int c, input int pg,
                                                input logic [2:0] off);
        logic [7:0] top;
        logic [7:0] bot;
        logic [7:0] v;
        top = sprite_mem[c];
        bot = sprite_mem[SPRITE_COLS + c];
        if (off == 3'd0)
            v = (pg == 0) ? top : bot;
        else if (pg == 0)
            v = top << off;
        else if (pg == 1)
            v = (top >> (8 - off)) | (bot << off);
        else
            v = bot >> (8 - off);
        return v;
    endfunction

    // Queue the writes for one controller: per page, column-set, page-set,
    // then the data of sprite columns first .. first+count-1.
    function automatic void queue_chip_part(input logic chip, input int col,
                                            input int first, input int count,
                                            input logic mirror, input int npages,
                                            input logic [2:0] page0,
                                            input logic [2:0] off);
        logic [5:0] ccol;
        logic [2:0] pg;
        int         c;
        ccol = col[5:0];
        for (int p = 0; p < npages; p++)
        begin
            pg = page0 + p[2:0];   // pages past the bottom wrap to the top
            pending_writes.push_back('{chip, 1'b0, CMD_COL_SET | {2'b00, ccol}, 1'b0});
            pending_writes.push_back('{chip, 1'b0, CMD_PAGE_SET | {5'b0, pg}, 1'b0});
            for (int i = first; i < first + count; i++)
            begin
                c = mirror ? (SPRITE_COLS - 1 - i) : i;
                pending_writes.push_back('{chip, 1'b1, pixel_column(c, p, off), 1'b0});
            end
        end
    endfunction

    // Expected write stream of one draw, appended behind what is still due.
    function automatic void predict_draw(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                                         input logic mirror);
        int         xi;
        int         left_cols;
        int         npages;
        logic [2:0] page0;
        logic [2:0] off;
        xi     = x;
        page0  = y[5:3];
        off    = y[2:0];
        npages = (off != 3'd0) ? 3 : 2;
        if (xi + SPRITE_COLS >= COLS_PER_CHIP && xi < COLS_PER_CHIP)
        begin
            // Crossing column 64: left part on chip 0, remainder on chip 1 at
            // column 0. At the lowest crossing x the right part has no data.
            left_cols = COLS_PER_CHIP - xi;
            queue_chip_part(1'b0, xi, 0, left_cols, mirror, npages, page0, off);
            queue_chip_part(1'b1, 0, left_cols, SPRITE_COLS - left_cols, mirror,
                            npages, page0, off);
            split_draws++;
        end
        else if (xi >= COLS_PER_CHIP)
            queue_chip_part(1'b1, xi - COLS_PER_CHIP, 0, SPRITE_COLS, mirror,
                            npages, page0, off);
        else
            queue_chip_part(1'b0, xi, 0, SPRITE_COLS, mirror, npages, page0, off);
        pending_writes[pending_writes.size() - 1].last = 1'b1;
        if (mirror)
            mirrored_draws++;
        if (int'(page0) + npages > 8)
            wrapped_draws++;
    endfunction

    // ------------------------------------------------------------------------
    // Item channel
    // ------------------------------------------------------------------------

    // Present one item and hold it until accepted. Valid stays high on exit
    // so a following item in the same burst goes out back to back.
    task automatic send_item(input logic item_op, input logic [IDX_W-1:0] idx,
                             input logic [7:0] val, input logic [X_W-1:0] x,
                             input logic [Y_W-1:0] y, input logic mirror);
        item_valid  <= 1'b1;
        op          <= item_op;
        byte_index  <= idx;
        byte_value  <= val;
        pos_x       <= x;
        pos_y       <= y;
        facing_left <= mirror;
        do
            @(posedge clk);
        while (!item_ready);
        if (item_op == OP_LOAD)
        begin
            if (int'(idx) < STORE_DEPTH)
                sprite_mem[idx] = val;
            loads_sent++;
        end
        else
        begin
            predict_draw(x, y, mirror);
            draws_sent++;
        end
    endtask

    task automatic load_byte(input int idx, input logic [7:0] val);
        send_item(OP_LOAD, idx[IDX_W-1:0], val, X_W'($urandom()), Y_W'($urandom()),
                  1'($urandom()));
    endtask

    task automatic draw_sprite(input int x, input int y, input logic mirror);
        send_item(OP_DRAW, IDX_W'($urandom()), 8'($urandom()), x[X_W-1:0], y[Y_W-1:0],
                  mirror);
    endtask

    // Drop valid and idle the sender for a number of cycles.
    task automatic sender_gap(input int cycles);
        item_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop valid and hold until every predicted write has been seen.
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Write channel: stall pattern and checker
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rx_hold == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_hold <= $urandom_range(16, 96);
        end
        else
            rx_hold <= rx_hold - 1;
        case (rx_mode)
            RX_STREAM: wr_ready <= 1'b1;
            RX_COIN:   wr_ready <= ($urandom_range(0, 1) == 1);
            RX_HICCUP: wr_ready <= ($urandom_range(0, 7) != 0);
            RX_CHOKE:  wr_ready <= ($urandom_range(0, 7) == 0);
            default:   wr_ready <= 1'b1;
        endcase
    end

    // Compare each accepted beat against the oldest predicted write.
    always @(posedge clk)
    begin
        bus_write_t exp_wr;
        if (rst_n && wr_valid && wr_ready)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("unexpected write beat: chip_sel %0d is_data %0d bus_byte 0x%02h last %0d",
                       chip_sel, is_data, bus_byte, last);
                error_count++;
            end
            else
            begin
                exp_wr = pending_writes.pop_front();
                beats_checked++;
                if (chip_sel !== exp_wr.chip)
                begin
                    $error("chip_sel mismatch: expected %0d, actual %0d", exp_wr.chip, chip_sel);
                    error_count++;
                end
                if (is_data !== exp_wr.is_data)
                begin
                    $error("is_data mismatch: expected %0d, actual %0d", exp_wr.is_data, is_data);
                    error_count++;
                end
                if (bus_byte !== exp_wr.data)
                begin
                    $error("bus_byte mismatch: expected 0x%02h, actual 0x%02h",
                           exp_wr.data, bus_byte);
                    error_count++;
                end
                if (last !== exp_wr.last)
                begin
                    $error("last mismatch: expected %0d, actual %0d", exp_wr.last, last);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Fill every store slot before any draw; hit both byte extremes and
    // single-bit patterns at the top and bottom rows.
    task automatic test_sprite_load();
        logic [7:0] val;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            case (i)
                0:       val = 8'h00;
                1:       val = 8'hFF;
                2:       val = 8'h01;
                3:       val = 8'h80;
                16:      val = 8'hFF;
                17:      val = 8'h00;
                31:      val = 8'h81;
                default: val = 8'($urandom());
            endcase
            load_byte(i, val);
        end
    endtask

    // Row offset zero: two pages, plain and mirrored.
    task automatic test_aligned_draws();
        draw_sprite(0, 0, 1'b0);
        draw_sprite(0, 0, 1'b1);
        draw_sprite(20, 48, 1'b0);
    endtask

    // Nonzero row offsets: three pages with shifted and merged bytes.
    task automatic test_row_offsets();
        draw_sprite(5, 1, 1'b0);
        draw_sprite(30, 7, 1'b1);
        draw_sprite(10, 47, 1'b0);
    endtask

    // Sprites around the controller boundary, including the crossing with an
    // empty right part and one landing exactly on chip 1 column 0.
    task automatic test_chip_split();
        draw_sprite(COLS_PER_CHIP - SPRITE_COLS, 0, 1'b0);
        draw_sprite(COLS_PER_CHIP - SPRITE_COLS + 1, 3, 1'b1);
        draw_sprite(COLS_PER_CHIP - 1, 8, 1'b0);
        draw_sprite(COLS_PER_CHIP - 8, 13, 1'b1);
        draw_sprite(COLS_PER_CHIP, 16, 1'b0);
        draw_sprite(112, 40, 1'b1);
    endtask

    // Past the right screen edge and past the bottom page (page wrap).
    task automatic test_screen_edges();
        draw_sprite(127, 63, 1'b1);
        draw_sprite(120, 56, 1'b0);
        draw_sprite(47, 60, 1'b0);
    endtask

    // Random mix of loads and draws in bursts; a quarter of the draws cluster
    // near the boundary and a quarter sit on aligned rows, to reach the less common paths.
    task automatic test_random_traffic(input int n_items);
        int         burst_left;
        int         gap;
        int         x;
        int         y;
        burst_left = $urandom_range(1, 8);
        for (int n = 0; n < n_items; n++)
        begin
            if (n == n_items / 2)
                wait_drained();   // let the stream run dry once mid-run
            if ($urandom_range(0, 3) == 0)
                load_byte($urandom_range(0, STORE_DEPTH - 1), 8'($urandom()));
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    x = $urandom_range(COLS_PER_CHIP - SPRITE_COLS - 4, COLS_PER_CHIP + 4);
                else
                    x = $urandom_range(0, 127);
                if ($urandom_range(0, 3) == 0)
                    y = $urandom_range(0, 7) * 8;
                else
                    y = $urandom_range(0, 63);
                draw_sprite(x, y, 1'($urandom_range(0, 1)));
            end
            burst_left--;
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 6);
                if (gap != 0)
                    sender_gap(gap);
                burst_left = $urandom_range(1, 8);
            end
        end
        item_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        int spin;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sprite_load();
        test_aligned_draws();
        test_row_offsets();
        test_chip_split();
        test_screen_edges();
        test_random_traffic(150);

        // Drain the remaining writes, then idle the block to show any stray
        // beat.
        spin = 0;
        while (pending_writes.size() != 0 && spin < 50000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (16) @(posedge clk);
        if (pending_writes.size() != 0)
        begin
            $error("%0d predicted writes never arrived", pending_writes.size());
            error_count++;
        end

        $display("Run covered %0d sprite loads and %0d draws: %0d split across controllers,",
                 loads_sent, draws_sent, split_draws);
        $display("%0d mirrored, %0d wrapping past the last page; %0d write beats checked.",
                 mirrored_draws, wrapped_draws, beats_checked);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #(10_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
